// File: src/cfa_pkg.sv
`timescale 1ns / 1ps
// cfa_pkg: shared constants, angle table and types of the attitude filter
// no dependencies; used by cfa_cordic, cfa_mac and complementary_filter_attitude

package cfa_pkg;

    // default parameter values
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANGLE_FRAC_DEF   = 16;

    // field widths
    localparam int TIME_W     = 32;
    localparam int RAW_W      = 16;
    localparam int ANGLE_W    = 32;
    localparam int INTERVAL_W = 10;
    localparam int WEIGHT_W   = 17;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 1;

    // cordic
    localparam int TAB_LEN  = 24;
    localparam int TAB_FRAC = 24;
    localparam int IDX_W    = 5;
    localparam int XY_W     = 36;
    localparam int Z_W      = 36;
    localparam int XY_SCALE = 16;

    // shared multiplier and blend accumulator
    localparam int MUL_W    = 18;
    localparam int PROD_W   = 36;
    localparam int ACC_W    = 54;
    localparam int G_W      = 34;
    localparam int D_W      = 35;
    localparam int HI_SPLIT = 17;
    localparam int BLEND_SH = 16;
    localparam int GYRO_SH  = 14;

    // register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT   = 1'd1;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 10'd10;
    localparam logic [WEIGHT_W-1:0]   WEIGHT_RST   = 17'd64225;
    localparam logic [WEIGHT_W-1:0]   WEIGHT_ONE   = 17'd65536;

    localparam logic signed [Z_W-1:0] HALF_TURN_Q24 = 36'sd3019898880;

    // atan(2^-i) in degrees, 24 fraction bits
    localparam logic [31:0] ATAN_DEG_Q24 [TAB_LEN] = '{
        32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
        32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
        32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
        32'd234684,    32'd117342,    32'd58671,     32'd29335,
        32'd14668,     32'd7334,      32'd3667,      32'd1833,
        32'd917,       32'd458,       32'd229,       32'd115
    };

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_ADD_SH
    } t_acc_op;

    typedef struct packed {
        logic    mul_en;
        t_acc_op acc_op;
    } t_mac_ctrl;

    typedef enum logic [1:0] {
        C_IDLE,
        C_ITER,
        C_ROUND,
        C_DONE
    } t_cord_state;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GYRO,
        S_PITCH_GO,
        S_PITCH_WAIT,
        S_ROLL_GO,
        S_ROLL_WAIT,
        S_DIFF,
        S_MUL_LO,
        S_MUL_HI,
        S_ACC_HI,
        S_ROUND,
        S_OUT
    } t_seq_state;

endpackage

// File: src/cfa_cordic.sv
`timescale 1ns / 1ps
// cfa_cordic: iterative vectoring cordic, atan2(y, x) in degrees, one step per cycle
// depends on cfa_pkg

module cfa_cordic #(
    parameter int CORDIC_STEPS    = cfa_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = cfa_pkg::ANGLE_FRAC_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [cfa_pkg::RAW_W-1:0]  i_y,
    input  logic signed [cfa_pkg::RAW_W-1:0]  i_x,
    output logic                              o_done,
    output logic signed [ANGLE_FRAC_BITS+8:0] o_result
);

    localparam int ANG_W  = ANGLE_FRAC_BITS + 9;
    localparam int XY_W   = cfa_pkg::XY_W;
    localparam int Z_W    = cfa_pkg::Z_W;
    localparam int IDX_W  = cfa_pkg::IDX_W;
    localparam int N_ITER = (CORDIC_STEPS > cfa_pkg::TAB_LEN) ? cfa_pkg::TAB_LEN : CORDIC_STEPS;
    localparam int RND_SH = cfa_pkg::TAB_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [Z_W-1:0] RND_HALF = Z_W'(2 ** (RND_SH - 1));
    localparam logic [IDX_W-1:0] I_LAST = IDX_W'(N_ITER - 1);

    cfa_pkg::t_cord_state r_state, n_state;

    logic signed [XY_W-1:0]            r_x, r_y;
    logic signed [Z_W-1:0]             r_z;
    logic [IDX_W-1:0]                  r_i;
    logic signed [ANG_W-1:0]           r_res;

    logic                              x_neg;
    logic signed [cfa_pkg::RAW_W:0]    x_ext, y_ext, x_abs, y_rot;
    logic signed [Z_W-1:0]             z_init;
    logic signed [XY_W-1:0]            dx, dy;
    logic signed [Z_W-1:0]             tab_val;
    logic signed [Z_W-1:0]             z_sum, z_shift;

    // pre-rotation by a half turn for negative x
    always_comb begin
        x_neg = i_x[cfa_pkg::RAW_W-1];
        x_ext = (cfa_pkg::RAW_W + 1)'(i_x);
        y_ext = (cfa_pkg::RAW_W + 1)'(i_y);
        x_abs = x_neg ? -x_ext : x_ext;
        y_rot = x_neg ? -y_ext : y_ext;
        if (!x_neg) begin
            z_init = '0;
        end else if (i_y[cfa_pkg::RAW_W-1]) begin
            z_init = -cfa_pkg::HALF_TURN_Q24;
        end else begin
            z_init = cfa_pkg::HALF_TURN_Q24;
        end
    end

    always_comb begin
        dx      = r_y >>> r_i;
        dy      = r_x >>> r_i;
        tab_val = Z_W'(cfa_pkg::ATAN_DEG_Q24[r_i]);
        z_sum   = r_z + RND_HALF - Z_W'(r_z[Z_W-1]);
        z_shift = z_sum >>> RND_SH;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cfa_pkg::C_IDLE: begin
                if (i_start) begin
                    n_state = cfa_pkg::C_ITER;
                end
            end
            cfa_pkg::C_ITER: begin
                if (r_i == I_LAST) begin
                    n_state = cfa_pkg::C_ROUND;
                end
            end
            cfa_pkg::C_ROUND: n_state = cfa_pkg::C_DONE;
            cfa_pkg::C_DONE:  n_state = cfa_pkg::C_IDLE;
            default:          n_state = cfa_pkg::C_IDLE;
        endcase
    end

    always_comb begin
        o_done   = (r_state == cfa_pkg::C_DONE);
        o_result = r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cfa_pkg::C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == cfa_pkg::C_IDLE && i_start) begin
            r_x <= XY_W'(x_abs) <<< cfa_pkg::XY_SCALE;
            r_y <= XY_W'(y_rot) <<< cfa_pkg::XY_SCALE;
            r_z <= z_init;
            r_i <= '0;
        end else if (r_state == cfa_pkg::C_ITER) begin
            if (!r_y[XY_W-1]) begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + tab_val;
            end else begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - tab_val;
            end
            r_i <= r_i + 1'b1;
        end else if (r_state == cfa_pkg::C_ROUND) begin
            r_res <= ANG_W'(z_shift);
        end
    end

endmodule

// File: src/cfa_mac.sv
`timescale 1ns / 1ps
// cfa_mac: shared 18x18 signed multiplier with product register and blend accumulator
// depends on cfa_pkg; rounds and saturates the accumulator to a 32-bit angle

module cfa_mac (
    input  logic                               i_clk,
    input  cfa_pkg::t_mac_ctrl                 i_ctrl,
    input  logic signed [cfa_pkg::MUL_W-1:0]   i_op_a,
    input  logic signed [cfa_pkg::MUL_W-1:0]   i_op_b,
    input  logic signed [cfa_pkg::ACC_W-1:0]   i_load,
    output logic signed [cfa_pkg::PROD_W-1:0]  o_prod,
    output logic signed [cfa_pkg::ANGLE_W-1:0] o_round
);

    localparam int ACC_W = cfa_pkg::ACC_W;
    localparam int RND_W = ACC_W - cfa_pkg::BLEND_SH;
    localparam int OUT_W = cfa_pkg::ANGLE_W;
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(2 ** (cfa_pkg::BLEND_SH - 1));
    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

    logic signed [cfa_pkg::PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]           r_acc;
    logic signed [ACC_W-1:0]           acc_sum, acc_shift;
    logic signed [RND_W-1:0]           rnd;
    logic                              rnd_fits;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= i_op_a * i_op_b;
        end
        case (i_ctrl.acc_op)
            cfa_pkg::ACC_LOAD:   r_acc <= i_load;
            cfa_pkg::ACC_ADD:    r_acc <= r_acc + ACC_W'(r_prod);
            cfa_pkg::ACC_ADD_SH: r_acc <= r_acc + (ACC_W'(r_prod) <<< cfa_pkg::HI_SPLIT);
            default:             r_acc <= r_acc;
        endcase
    end

    // round half away from zero, then clamp
    always_comb begin
        acc_sum   = r_acc + RND_HALF - ACC_W'(r_acc[ACC_W-1]);
        acc_shift = acc_sum >>> cfa_pkg::BLEND_SH;
        rnd       = RND_W'(acc_shift);
        rnd_fits  = (&rnd[RND_W-1:OUT_W-1]) || !(|rnd[RND_W-1:OUT_W-1]);
        if (rnd_fits) begin
            o_round = OUT_W'(rnd);
        end else if (rnd[RND_W-1]) begin
            o_round = OUT_MIN;
        end else begin
            o_round = OUT_MAX;
        end
        o_prod = r_prod;
    end

endmodule

// File: src/complementary_filter_attitude.sv
`timescale 1ns / 1ps
// complementary_filter_attitude: top level, sequencer, angle state and registers
// depends on cfa_pkg, cfa_cordic and cfa_mac
//
// Input channel: i_in_valid with the timestamp and six raw imu readings, o_in_stall back.
// A request whose time since the last update is not above update_interval_ms is
// taken without a stall and gives no result. Otherwise the block stalls its input while
// it integrates the three gyro rates, runs two atan2 on the cordic unit and blends
// each angle through the shared multiplier, then loads the output register.
// Output channel: o_out_valid with yaw, pitch and roll, i_out_stall back.
// An updating request is integrated, runs the cordic twice and uses the 18x18
// multiplier twice per angle before o_out_valid; the next request can be taken
// in the same cycle as o_out_valid rises.
// A finished result waits in the output register while the receiver stalls, and a
// new request is accepted meanwhile; a second result then waits in the sequencer.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx (0 interval,
// 1 gyro weight) at the clock edge; write only while no request is in flight.
// Reset (synchronous, active low): angles and last update time cleared, interval 10,
// weight 64225, output empty, input ready.

module complementary_filter_attitude #(
    parameter int CORDIC_STEPS    = cfa_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = cfa_pkg::ANGLE_FRAC_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cfa_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [cfa_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [cfa_pkg::TIME_W-1:0]          i_time_ms,
    input  logic signed [cfa_pkg::RAW_W-1:0]    i_accel_x,
    input  logic signed [cfa_pkg::RAW_W-1:0]    i_accel_y,
    input  logic signed [cfa_pkg::RAW_W-1:0]    i_accel_z,
    input  logic signed [cfa_pkg::RAW_W-1:0]    i_gyro_x,
    input  logic signed [cfa_pkg::RAW_W-1:0]    i_gyro_y,
    input  logic signed [cfa_pkg::RAW_W-1:0]    i_gyro_z,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [cfa_pkg::ANGLE_W-1:0]  o_yaw_angle,
    output logic signed [cfa_pkg::ANGLE_W-1:0]  o_pitch_angle,
    output logic signed [cfa_pkg::ANGLE_W-1:0]  o_roll_angle
);

    localparam int ANG_W   = ANGLE_FRAC_BITS + 9;
    localparam int RAW_W   = cfa_pkg::RAW_W;
    localparam int MUL_W   = cfa_pkg::MUL_W;
    localparam int PROD_W  = cfa_pkg::PROD_W;
    localparam int ACC_W   = cfa_pkg::ACC_W;
    localparam int G_W     = cfa_pkg::G_W;
    localparam int D_W     = cfa_pkg::D_W;
    localparam int ANGLE_W = cfa_pkg::ANGLE_W;
    localparam int GY_R    = (ANGLE_FRAC_BITS >= cfa_pkg::GYRO_SH) ? 0 :
                             cfa_pkg::GYRO_SH - ANGLE_FRAC_BITS;
    localparam int GY_L    = (ANGLE_FRAC_BITS >= cfa_pkg::GYRO_SH) ?
                             ANGLE_FRAC_BITS - cfa_pkg::GYRO_SH : 0;
    localparam int GY_HALF = (GY_R > 0) ? 2 ** (GY_R - 1) : 0;

    localparam logic [1:0] K_YAW   = 2'd0;
    localparam logic [1:0] K_PITCH = 2'd1;
    localparam logic [1:0] K_ROLL  = 2'd2;
    localparam logic [2:0] GYRO_MUL_END = 3'd3;
    localparam logic [2:0] GYRO_LAST    = 3'd4;
    localparam logic [2:0] GYRO_WR_LAG  = 3'd2;

    cfa_pkg::t_seq_state r_state, n_state;

    // configuration
    logic [cfa_pkg::INTERVAL_W-1:0] r_interval;
    logic [cfa_pkg::WEIGHT_W-1:0]   r_weight;
    logic [cfa_pkg::WEIGHT_W-1:0]   w_sat;

    // filter state
    logic [cfa_pkg::TIME_W-1:0]     r_last;
    logic signed [ANGLE_W-1:0]      r_est [3];

    // captured request
    logic signed [RAW_W-1:0]        r_ax, r_ay, r_az, r_gx, r_gy, r_gz;

    // working registers
    logic [2:0]                     r_cnt;
    logic [1:0]                     r_k;
    logic signed [G_W-1:0]          r_step;
    logic signed [G_W-1:0]          r_g [3];
    logic signed [ANG_W-1:0]        r_a_pitch, r_a_roll;
    logic signed [D_W-1:0]          r_d;

    // output register
    logic                           r_out_valid;
    logic signed [ANGLE_W-1:0]      r_out_yaw, r_out_pitch, r_out_roll;

    logic [cfa_pkg::TIME_W-1:0]     elapsed;
    logic                           in_take, upd_take, out_free;
    logic [1:0]                     mul_idx, wr_idx;
    logic signed [RAW_W-1:0]        gyro_sel;
    logic signed [ANGLE_W-1:0]      est_sel;
    logic signed [PROD_W-1:0]       gsum, gshift;
    logic signed [G_W-1:0]          g_next;
    logic signed [ANG_W-1:0]        a_sel;

    cfa_pkg::t_mac_ctrl             mac_ctrl;
    logic signed [MUL_W-1:0]        op_a, op_b;
    logic signed [ACC_W-1:0]        acc_load;
    logic signed [PROD_W-1:0]       prod;
    logic signed [ANGLE_W-1:0]      mac_round;

    logic                           cord_start, cord_done;
    logic signed [RAW_W-1:0]        cord_y, cord_x;
    logic signed [ANG_W-1:0]        cord_res;

    cfa_cordic #(
        .CORDIC_STEPS    (CORDIC_STEPS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_cordic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (cord_start),
        .i_y      (cord_y),
        .i_x      (cord_x),
        .o_done   (cord_done),
        .o_result (cord_res)
    );

    cfa_mac u_mac (
        .i_clk   (i_clk),
        .i_ctrl  (mac_ctrl),
        .i_op_a  (op_a),
        .i_op_b  (op_b),
        .i_load  (acc_load),
        .o_prod  (prod),
        .o_round (mac_round)
    );

    // request decode
    always_comb begin
        elapsed  = i_time_ms - r_last;
        in_take  = i_in_valid && !o_in_stall;
        upd_take = in_take && (elapsed > cfa_pkg::TIME_W'(r_interval));
        out_free = !r_out_valid || !i_out_stall;
        w_sat    = r_weight[cfa_pkg::WEIGHT_W-1] ? cfa_pkg::WEIGHT_ONE : r_weight;
    end

    // gyro integration step, rounded half away from zero
    always_comb begin
        mul_idx = r_cnt[1:0];
        wr_idx  = 2'(r_cnt - GYRO_WR_LAG);
        case (mul_idx)
            K_YAW:   gyro_sel = r_gz;
            K_PITCH: gyro_sel = r_gx;
            default: gyro_sel = r_gy;
        endcase
        case (wr_idx)
            K_YAW:   est_sel = r_est[0];
            K_PITCH: est_sel = r_est[1];
            default: est_sel = r_est[2];
        endcase
        if (GY_R > 0) begin
            gsum = prod + PROD_W'(GY_HALF) - PROD_W'(prod[PROD_W-1]);
        end else begin
            gsum = prod;
        end
        gshift = (gsum >>> GY_R) <<< GY_L;
        if (wr_idx == K_ROLL) begin
            g_next = G_W'(est_sel) - r_step;
        end else begin
            g_next = G_W'(est_sel) + r_step;
        end
        case (r_k)
            K_YAW:   a_sel = '0;
            K_PITCH: a_sel = r_a_pitch;
            default: a_sel = r_a_roll;
        endcase
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cfa_pkg::S_IDLE: begin
                if (upd_take) begin
                    n_state = cfa_pkg::S_GYRO;
                end
            end
            cfa_pkg::S_GYRO: begin
                if (r_cnt == GYRO_LAST) begin
                    n_state = cfa_pkg::S_PITCH_GO;
                end
            end
            cfa_pkg::S_PITCH_GO: n_state = cfa_pkg::S_PITCH_WAIT;
            cfa_pkg::S_PITCH_WAIT: begin
                if (cord_done) begin
                    n_state = cfa_pkg::S_ROLL_GO;
                end
            end
            cfa_pkg::S_ROLL_GO: n_state = cfa_pkg::S_ROLL_WAIT;
            cfa_pkg::S_ROLL_WAIT: begin
                if (cord_done) begin
                    n_state = cfa_pkg::S_DIFF;
                end
            end
            cfa_pkg::S_DIFF:   n_state = cfa_pkg::S_MUL_LO;
            cfa_pkg::S_MUL_LO: n_state = cfa_pkg::S_MUL_HI;
            cfa_pkg::S_MUL_HI: n_state = cfa_pkg::S_ACC_HI;
            cfa_pkg::S_ACC_HI: n_state = cfa_pkg::S_ROUND;
            cfa_pkg::S_ROUND: begin
                if (r_k == K_ROLL) begin
                    n_state = cfa_pkg::S_OUT;
                end else begin
                    n_state = cfa_pkg::S_DIFF;
                end
            end
            cfa_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = cfa_pkg::S_IDLE;
                end
            end
            default: n_state = cfa_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_stall      = (r_state != cfa_pkg::S_IDLE);
        mac_ctrl.mul_en = 1'b0;
        mac_ctrl.acc_op = cfa_pkg::ACC_HOLD;
        op_a            = MUL_W'(gyro_sel);
        op_b            = $signed(MUL_W'(r_interval));
        acc_load        = ACC_W'(a_sel) <<< cfa_pkg::BLEND_SH;
        cord_start      = 1'b0;
        cord_y          = r_ay;
        cord_x          = r_ax;
        unique case (r_state)
            cfa_pkg::S_GYRO: begin
                mac_ctrl.mul_en = (r_cnt < GYRO_MUL_END);
            end
            cfa_pkg::S_PITCH_GO: begin
                cord_start = 1'b1;
            end
            cfa_pkg::S_ROLL_GO: begin
                cord_start = 1'b1;
                cord_y     = r_ax;
                cord_x     = r_az;
            end
            cfa_pkg::S_DIFF: begin
                mac_ctrl.acc_op = cfa_pkg::ACC_LOAD;
            end
            cfa_pkg::S_MUL_LO: begin
                mac_ctrl.mul_en = 1'b1;
                op_a            = $signed({1'b0, r_d[cfa_pkg::HI_SPLIT-1:0]});
                op_b            = $signed({1'b0, w_sat});
            end
            cfa_pkg::S_MUL_HI: begin
                mac_ctrl.mul_en = 1'b1;
                mac_ctrl.acc_op = cfa_pkg::ACC_ADD;
                op_a            = $signed(r_d[D_W-1:cfa_pkg::HI_SPLIT]);
                op_b            = $signed({1'b0, w_sat});
            end
            cfa_pkg::S_ACC_HI: begin
                mac_ctrl.acc_op = cfa_pkg::ACC_ADD_SH;
            end
            default: begin
                mac_ctrl.mul_en = 1'b0;
            end
        endcase
    end

    // control and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cfa_pkg::S_IDLE;
            r_cnt       <= '0;
            r_k         <= K_YAW;
            r_last      <= '0;
            r_est[0]    <= '0;
            r_est[1]    <= '0;
            r_est[2]    <= '0;
            r_interval  <= cfa_pkg::INTERVAL_RST;
            r_weight    <= cfa_pkg::WEIGHT_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    cfa_pkg::CFG_INTERVAL: r_interval <= i_cfg_data[cfa_pkg::INTERVAL_W-1:0];
                    default:               r_weight   <= i_cfg_data;
                endcase
            end
            if (upd_take) begin
                r_last <= i_time_ms;
                r_cnt  <= '0;
            end else if (r_state == cfa_pkg::S_GYRO) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (r_state == cfa_pkg::S_ROLL_WAIT && cord_done) begin
                r_k <= K_YAW;
            end else if (r_state == cfa_pkg::S_ROUND) begin
                r_est[r_k] <= mac_round;
                r_k        <= r_k + 1'b1;
            end
            if (r_state == cfa_pkg::S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (upd_take) begin
            r_ax <= i_accel_x;
            r_ay <= i_accel_y;
            r_az <= i_accel_z;
            r_gx <= i_gyro_x;
            r_gy <= i_gyro_y;
            r_gz <= i_gyro_z;
        end
        if (r_state == cfa_pkg::S_GYRO && r_cnt != '0 && r_cnt != GYRO_LAST) begin
            r_step <= G_W'(gshift);
        end
        if (r_state == cfa_pkg::S_GYRO && r_cnt >= GYRO_WR_LAG) begin
            r_g[wr_idx] <= g_next;
        end
        if (r_state == cfa_pkg::S_PITCH_WAIT && cord_done) begin
            r_a_pitch <= cord_res;
        end
        if (r_state == cfa_pkg::S_ROLL_WAIT && cord_done) begin
            r_a_roll <= cord_res;
        end
        if (r_state == cfa_pkg::S_DIFF) begin
            r_d <= D_W'(r_g[r_k]) - D_W'(a_sel);
        end
        if (r_state == cfa_pkg::S_OUT && out_free) begin
            r_out_yaw   <= r_est[0];
            r_out_pitch <= r_est[1];
            r_out_roll  <= r_est[2];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_yaw_angle   = r_out_yaw;
    assign o_pitch_angle = r_out_pitch;
    assign o_roll_angle  = r_out_roll;

endmodule
